// ===== rtl/voxel_chunk_owner_mapper_assert.svh =====
// Assertion macros shared by the voxel chunk owner mapper RTL.
`ifndef VOXEL_CHUNK_OWNER_MAPPER_ASSERT_SVH
`define VOXEL_CHUNK_OWNER_MAPPER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define VCOM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define VCOM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/vcom_pkg.sv =====
// Types, constants and helper functions of the voxel chunk owner mapper.
package vcom_pkg;

    // Share scale and hash constants
    localparam int unsigned SHARE_ONE  = 10000;
    localparam logic [31:0] HASH_MUL_A = 32'd2654435761;
    localparam logic [31:0] HASH_MUL_B = 32'd2246822519;
    // ceil(2^45 / 10000): exact quotient for every 32-bit dividend
    localparam logic [31:0] MOD_RECIP  = 32'd3518437209;
    localparam int unsigned MOD_SHIFT  = 45;

    // Widths
    localparam int unsigned CW  = 16;   // cell / chunk coordinate width
    localparam int unsigned QW  = 17;   // quotient width (round-up grid count)
    localparam int unsigned SW  = 14;   // share width
    localparam int unsigned CFG_DW = 16;
    localparam int unsigned CFG_IW = 3;

    // Divider geometry
    localparam int unsigned DIV_LANES = 6;
    localparam int unsigned DIV_BPS   = 2;
    localparam int unsigned DIV_NS    = (QW + DIV_BPS - 1) / DIV_BPS;

    // Back-end stages
    localparam int unsigned IDX_NS = 9;

    // Register indexes
    localparam logic [CFG_IW-1:0] REG_MODE     = 3'd0;
    localparam logic [CFG_IW-1:0] REG_SCENARIO = 3'd1;
    localparam logic [CFG_IW-1:0] REG_SHARE    = 3'd2;
    localparam logic [CFG_IW-1:0] REG_LAYER    = 3'd3;
    localparam logic [CFG_IW-1:0] REG_CWIDTH   = 3'd4;
    localparam logic [CFG_IW-1:0] REG_CHEIGHT  = 3'd5;
    localparam logic [CFG_IW-1:0] REG_CDEPTH   = 3'd6;

    // Scenario codes
    localparam logic [1:0] SCEN_BALANCED  = 2'd0;
    localparam logic [1:0] SCEN_PRIMARY   = 2'd1;
    localparam logic [1:0] SCEN_SECONDARY = 2'd2;

    // One divider lane: partial remainder and numerator/quotient shifter
    typedef struct packed {
        logic [CW-1:0] rem;
        logic [QW-1:0] nq;
    } t_dlane;

    // Chunk coordinates and grid counts after division
    typedef struct packed {
        logic [31:0]   seq;
        logic [CW-1:0] cx;
        logic [CW-1:0] cy;
        logic [CW-1:0] cz;
        logic [QW-1:0] gx;
        logic [QW-1:0] gy;
        logic [QW-1:0] gz;
    } t_chunk;

    // Owner selection controls, derived from configuration
    typedef struct packed {
        logic [SW-1:0] share;
        logic [SW-1:0] plane_share;
        logic          share_zero;
        logic          share_full;
        logic          plane_en;
        logic          plane_z;
        logic          plane_sec;
    } t_ctl;

    // Back-end stage payload
    typedef struct packed {
        logic [31:0]   seq;
        logic [CW-1:0] cx;
        logic [CW-1:0] cy;
        logic [CW-1:0] cz;
        logic [QW-1:0] gx;
        logic [31:0]   acc;
        logic [31:0]   lin;
        logic [31:0]   h;
        logic [63:0]   prod;
        logic [31:0]   pl_l;
        logic [31:0]   pl_r;
        logic          flat;
        logic          below;
        logic [SW-1:0] rem;
        logic          owner;
    } t_idx;

    // One restoring division step
    function automatic t_dlane div_step(input t_dlane x, input logic [CW-1:0] d);
        logic [CW:0] t;
        logic        ge;
        t_dlane      y;
        t  = {x.rem, x.nq[QW-1]};
        ge = (t >= {1'b0, d});
        y.nq  = {x.nq[QW-2:0], ge};
        y.rem = ge ? CW'(t - {1'b0, d}) : t[CW-1:0];
        return y;
    endfunction

endpackage

// ===== rtl/vcom_divider.sv =====
// Pipelined restoring divider: six lanes, two quotient bits per stage.
`include "voxel_chunk_owner_mapper_assert.svh"
module vcom_divider (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [31:0]            i_seq,
    input  logic [vcom_pkg::QW-1:0] i_num [vcom_pkg::DIV_LANES],
    input  logic [vcom_pkg::CW-1:0] i_div [3],
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [31:0]            o_seq,
    output logic [vcom_pkg::QW-1:0] o_quot [vcom_pkg::DIV_LANES]
);
    localparam int unsigned NS = vcom_pkg::DIV_NS;
    localparam int unsigned NL = vcom_pkg::DIV_LANES;

    logic              [NS-1:0] r_v;
    logic              [NS:0]   en;
    logic              [NS-1:0] v_src;
    logic [31:0]                r_seq [NS];
    vcom_pkg::t_dlane           r_ln  [NS][NL];
    vcom_pkg::t_dlane           n_ln  [NS][NL];
    logic                       rem_ok;

    // Stage enables: a stage moves when it is empty or its successor moves
    assign en[NS] = !i_stall;
    for (genvar k = 0; k < NS; k++) begin : g_en
        assign en[k] = !r_v[k] || en[k+1];
    end
    assign o_stall = !en[0];
    assign v_src   = {r_v[NS-2:0], i_valid};

    // Division steps of each stage
    always_comb begin
        vcom_pkg::t_dlane x;
        for (int k = 0; k < NS; k++) begin
            for (int l = 0; l < NL; l++) begin
                if (k == 0) begin
                    x.rem = '0;
                    x.nq  = i_num[l];
                end else begin
                    x = r_ln[(k == 0) ? 0 : k-1][l];
                end
                for (int j = 0; j < vcom_pkg::DIV_BPS; j++) begin
                    if (k * vcom_pkg::DIV_BPS + j < vcom_pkg::QW) begin
                        x = vcom_pkg::div_step(x, i_div[l % 3]);
                    end
                end
                n_ln[k][l] = x;
            end
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (en[k]) begin
                    r_v[k] <= v_src[k];
                end
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NS; k++) begin
            if (en[k]) begin
                r_seq[k] <= (k == 0) ? i_seq : r_seq[(k == 0) ? 0 : k-1];
                for (int l = 0; l < NL; l++) begin
                    r_ln[k][l] <= n_ln[k][l];
                end
            end
        end
    end

    assign o_valid = r_v[NS-1];
    assign o_seq   = r_seq[NS-1];
    for (genvar l = 0; l < NL; l++) begin : g_out
        assign o_quot[l] = r_ln[NS-1][l].nq;
    end

    // Remainder check on the last stage
    always_comb begin
        rem_ok = 1'b1;
        for (int l = 0; l < NL; l++) begin
            if (r_ln[NS-1][l].rem >= i_div[l % 3]) begin
                rem_ok = 1'b0;
            end
        end
    end

    `VCOM_ASSERT_IMP(a_div_rem, i_clk, i_rst_n, o_valid, rem_ok, "divider remainder out of range")
endmodule

// ===== rtl/vcom_index.sv =====
// Back end: linear chunk index, hash, plane test and owner choice.
`include "voxel_chunk_owner_mapper_assert.svh"
module vcom_index (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  vcom_pkg::t_chunk i_chunk,
    input  vcom_pkg::t_ctl   i_ctl,
    output logic             o_valid,
    input  logic             i_stall,
    output vcom_pkg::t_idx   o_res
);
    localparam int unsigned NS = vcom_pkg::IDX_NS;

    logic           [NS-1:0] r_v;
    logic           [NS:0]   en;
    logic           [NS-1:0] v_src;
    vcom_pkg::t_idx          r_p [NS];
    vcom_pkg::t_idx          n_p [NS];
    vcom_pkg::t_idx          s0;

    // Work done by stage k on the beat it receives
    function automatic vcom_pkg::t_idx stage_op(input int k, input vcom_pkg::t_idx p,
                                                 input vcom_pkg::t_ctl c);
        vcom_pkg::t_idx y;
        logic [31:0]    q;
        y = p;
        case (k)
            1: begin
                y.acc   = p.acc + 32'(p.cy);
                y.below = p.flat || (p.pl_l < p.pl_r);
            end
            2: y.acc = 32'(p.gx) * p.acc;
            3: y.lin = p.acc + 32'(p.cx);
            4: y.h   = p.lin * vcom_pkg::HASH_MUL_A;
            5: y.h   = (p.h ^ (p.h >> 16)) * vcom_pkg::HASH_MUL_B;
            6: begin
                y.h    = p.h ^ (p.h >> 13);
                y.prod = 64'(y.h) * 64'(vcom_pkg::MOD_RECIP);
            end
            7: begin
                q     = 32'(p.prod[63:vcom_pkg::MOD_SHIFT]);
                y.rem = vcom_pkg::SW'(p.h - q * 32'(vcom_pkg::SHARE_ONE));
            end
            8: begin
                if (c.share_zero) begin
                    y.owner = 1'b0;
                end else if (c.share_full) begin
                    y.owner = 1'b1;
                end else if (c.plane_en) begin
                    y.owner = c.plane_sec ? p.below : !p.below;
                end else begin
                    y.owner = (p.rem < c.share);
                end
            end
            default: ;
        endcase
        return y;
    endfunction

    // Entry stage: first product of the index and the plane operands
    always_comb begin
        logic [vcom_pkg::CW-1:0] c;
        logic [vcom_pkg::QW-1:0] g;
        c = i_ctl.plane_z ? i_chunk.cz : i_chunk.cx;
        g = i_ctl.plane_z ? i_chunk.gz : i_chunk.gx;
        s0       = '0;
        s0.seq   = i_chunk.seq;
        s0.cx    = i_chunk.cx;
        s0.cy    = i_chunk.cy;
        s0.cz    = i_chunk.cz;
        s0.gx    = i_chunk.gx;
        s0.acc   = 32'(i_chunk.gy) * 32'(i_chunk.cz);
        s0.pl_l  = (32'(c) * 32'd2 + 32'd1) * 32'(vcom_pkg::SHARE_ONE);
        s0.pl_r  = 32'(g) * 32'(i_ctl.plane_share) * 32'd2;
        s0.flat  = (g <= vcom_pkg::QW'(1));
    end

    always_comb begin
        n_p[0] = s0;
        for (int k = 1; k < NS; k++) begin
            n_p[k] = stage_op(k, r_p[k-1], i_ctl);
        end
    end

    // Stage enables
    assign en[NS] = !i_stall;
    for (genvar k = 0; k < NS; k++) begin : g_en
        assign en[k] = !r_v[k] || en[k+1];
    end
    assign o_stall = !en[0];
    assign v_src   = {r_v[NS-2:0], i_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (en[k]) begin
                    r_v[k] <= v_src[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NS; k++) begin
            if (en[k]) begin
                r_p[k] <= n_p[k];
            end
        end
    end

    assign o_valid = r_v[NS-1];
    assign o_res   = r_p[NS-1];

    `VCOM_ASSERT_IMP(a_zero_share, i_clk, i_rst_n, o_valid && i_ctl.share_zero, !o_res.owner, "zero share gave secondary owner")
    `VCOM_ASSERT_IMP(a_full_share, i_clk, i_rst_n, o_valid && i_ctl.share_full && !i_ctl.share_zero, o_res.owner, "full share gave primary owner")
    `VCOM_ASSERT_IMP(a_hash_rem, i_clk, i_rst_n, o_valid, o_res.rem < vcom_pkg::SW'(vcom_pkg::SHARE_ONE), "hash remainder not below share scale")
    `VCOM_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid, "stalled result dropped")
endmodule

// ===== rtl/voxel_chunk_owner_mapper.sv =====
// Top level of the voxel chunk owner mapper: configuration and pipeline wiring.
//
// Input channel: one voxel per beat (sequence id, cell x/y/z, grid extents) on
// i_valid, accepted when o_stall is low. Output channel: global id, chunk id,
// linear chunk index and owner on o_valid, taken when i_stall is low.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index
// (0 mode, 1 scenario, 2 share, 3 layer, 4..6 chunk sizes); write only when
// the pipeline is empty. Indexes above 6 are ignored.
// The radix-4 divider pipeline (17 quotient bits, two per stage) feeds the
// index/hash back end. Throughput: one voxel per cycle while o_stall is low.
// Every stage holds a valid bit; a stage fills when empty, so bubbles close
// up and a stalled receiver only backs up the pipeline once every stage is
// full. Nothing is lost or repeated.
// Reset (synchronous, active low) empties the pipeline and loads the
// register defaults: hashed mode, balanced, share 0, layer 1, chunk size 1.
module voxel_chunk_owner_mapper (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [vcom_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [vcom_pkg::CFG_DW-1:0] i_cfg_data,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [31:0]                i_sequence_id,
    input  logic [15:0]                i_cell_x,
    input  logic [15:0]                i_cell_y,
    input  logic [15:0]                i_cell_z,
    input  logic [15:0]                i_grid_width,
    input  logic [15:0]                i_grid_height,
    input  logic [15:0]                i_grid_depth,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [47:0]                o_global_id,
    output logic [63:0]                o_chunk_id,
    output logic [31:0]                o_chunk_index,
    output logic                       o_owner
);
    logic                        r_mode;
    logic [1:0]                  r_scen;
    logic [vcom_pkg::SW-1:0]     r_share;
    logic [15:0]                 r_layer;
    logic [15:0]                 r_cw;
    logic [15:0]                 r_ch;
    logic [15:0]                 r_cd;

    logic [vcom_pkg::CW-1:0]     div_d   [3];
    logic [vcom_pkg::QW-1:0]     div_num [vcom_pkg::DIV_LANES];
    logic [vcom_pkg::QW-1:0]     div_q   [vcom_pkg::DIV_LANES];
    logic [31:0]                 div_seq;
    logic                        div_valid;
    logic                        idx_stall;
    logic [vcom_pkg::SW-1:0]     share_c;
    logic                        heavy;
    vcom_pkg::t_chunk            chunk;
    vcom_pkg::t_ctl              ctl;
    vcom_pkg::t_idx              res;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= 1'b0;
            r_scen  <= vcom_pkg::SCEN_BALANCED;
            r_share <= '0;
            r_layer <= 16'd1;
            r_cw    <= 16'd1;
            r_ch    <= 16'd1;
            r_cd    <= 16'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                vcom_pkg::REG_MODE:     r_mode  <= i_cfg_data[0];
                vcom_pkg::REG_SCENARIO: r_scen  <= i_cfg_data[1:0];
                vcom_pkg::REG_SHARE:    r_share <= i_cfg_data[vcom_pkg::SW-1:0];
                vcom_pkg::REG_LAYER:    r_layer <= i_cfg_data;
                vcom_pkg::REG_CWIDTH:   r_cw    <= i_cfg_data;
                vcom_pkg::REG_CHEIGHT:  r_ch    <= i_cfg_data;
                vcom_pkg::REG_CDEPTH:   r_cd    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Divisors: a zero chunk size acts as one
    assign div_d[0] = (r_cw == '0) ? 16'd1 : r_cw;
    assign div_d[1] = (r_ch == '0) ? 16'd1 : r_ch;
    assign div_d[2] = (r_cd == '0) ? 16'd1 : r_cd;

    // Cells divide plainly; extents round up
    assign div_num[0] = vcom_pkg::QW'(i_cell_x);
    assign div_num[1] = vcom_pkg::QW'(i_cell_y);
    assign div_num[2] = vcom_pkg::QW'(i_cell_z);
    assign div_num[3] = vcom_pkg::QW'(i_grid_width)  + vcom_pkg::QW'(div_d[0]) - 1'b1;
    assign div_num[4] = vcom_pkg::QW'(i_grid_height) + vcom_pkg::QW'(div_d[1]) - 1'b1;
    assign div_num[5] = vcom_pkg::QW'(i_grid_depth)  + vcom_pkg::QW'(div_d[2]) - 1'b1;

    vcom_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_seq   (i_sequence_id),
        .i_num   (div_num),
        .i_div   (div_d),
        .o_valid (div_valid),
        .i_stall (idx_stall),
        .o_seq   (div_seq),
        .o_quot  (div_q)
    );

    // Owner controls from the static configuration
    assign share_c = (r_share > vcom_pkg::SW'(vcom_pkg::SHARE_ONE))
                   ? vcom_pkg::SW'(vcom_pkg::SHARE_ONE) : r_share;
    assign heavy   = (r_scen == vcom_pkg::SCEN_PRIMARY) || (r_scen == vcom_pkg::SCEN_SECONDARY);

    always_comb begin
        ctl.share       = share_c;
        ctl.share_zero  = (share_c == '0);
        ctl.share_full  = (share_c == vcom_pkg::SW'(vcom_pkg::SHARE_ONE));
        ctl.plane_en    = heavy || r_mode;
        ctl.plane_z     = heavy;
        ctl.plane_sec   = (r_scen == vcom_pkg::SCEN_SECONDARY);
        ctl.plane_share = ctl.plane_sec ? share_c
                        : vcom_pkg::SW'(vcom_pkg::SW'(vcom_pkg::SHARE_ONE) - share_c);
    end

    always_comb begin
        chunk.seq = div_seq;
        chunk.cx  = div_q[0][vcom_pkg::CW-1:0];
        chunk.cy  = div_q[1][vcom_pkg::CW-1:0];
        chunk.cz  = div_q[2][vcom_pkg::CW-1:0];
        chunk.gx  = div_q[3];
        chunk.gy  = div_q[4];
        chunk.gz  = div_q[5];
    end

    vcom_index u_idx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (div_valid),
        .o_stall (idx_stall),
        .i_chunk (chunk),
        .i_ctl   (ctl),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (res)
    );

    // Result packing; user keeps layer stable with beats in flight, unchecked
    assign o_global_id   = {r_layer, res.seq};
    assign o_chunk_id    = {r_layer, res.cz, res.cy, res.cx};
    assign o_chunk_index = res.lin;
    assign o_owner       = res.owner;
endmodule
